// ===== rtl/two_operator_fm_voice_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-operator FM voice core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_OPERATOR_FM_VOICE_CORE_ASSERT_SVH
`define TWO_OPERATOR_FM_VOICE_CORE_ASSERT_SVH

// same-cycle implication
`define FMV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_pkg
// Shared constants, register codes and types of the FM voice core.
// ----------------------------------------------------------------------------
package fmv_pkg;

	localparam int unsigned VOICES_DEF          = 8;
	localparam int unsigned PHASE_BITS_DEF      = 24;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [15:0] MOD_INDEX_RST   = 16'd4096;
	localparam logic [15:0] MOD_RATIO_RST   = 16'd4096;
	localparam logic [19:0] PHASE_SCALE_RST = 20'd89478;

	// round(2^32 / (2*pi))
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

	typedef enum logic [1:0] {
		REG_MOD_INDEX   = 2'd0,
		REG_MOD_RATIO   = 2'd1,
		REG_PHASE_SCALE = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ACT_START  = 1'b0,
		ACT_RENDER = 1'b1
	} action_t;

	typedef struct packed {
		logic [15:0] mod_index;
		logic [15:0] mod_ratio;
		logic [19:0] phase_scale;
	} cfg_t;

endpackage

// ===== rtl/two_operator_fm_voice_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_operator_fm_voice_core
// Two-operator FM voice bank: per-voice phase and note memories, a shared
// sine ROM and a registered multiplier chain driven by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+----------------------------------
//  input     | in_valid / in_ready         | action, voice, frequency_hz,
//            |                             | velocity, envelope_level, mix_in
//  output    | out_valid / out_ready       | mix_out
//  config    | APB psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
//  A start transaction is taken without leaving the idle state; a render
//  transaction steps through the memory read, two reads of the shared
//  sine ROM and the chain of registered multipliers (offset, carrier step,
//  amplitude). A render to a voice beyond the bank goes to the output state
//  directly and passes mix_in on. The result waits in the output register; the
//  next transaction is taken once it has been loaded, an output stall delays it.
//  Reset loads the register defaults; voice state reads as zero until written.
// ----------------------------------------------------------------------------
`include "two_operator_fm_voice_core_assert.svh"

module two_operator_fm_voice_core #(
	parameter int unsigned VOICES          = fmv_pkg::VOICES_DEF,
	parameter int unsigned PHASE_BITS      = fmv_pkg::PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = fmv_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fmv_pkg::ADDR_W-1:0] paddr,
	input  logic [fmv_pkg::DATA_W-1:0] pwdata,
	output logic [fmv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [2:0]                 voice,
	input  logic [22:0]                frequency_hz,
	input  logic [15:0]                velocity,
	input  logic [15:0]                envelope_level,
	input  logic signed [15:0]         mix_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [15:0]         mix_out
);

	localparam int unsigned AW     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int unsigned CAR_SH = 40 - PHASE_BITS;
	localparam int unsigned MOD_SH = 52 - PHASE_BITS;
	localparam int unsigned OFS_SH = 59 - PHASE_BITS;
	localparam int unsigned PH_W   = 2 * PHASE_BITS;
	localparam int unsigned NOTE_W = 23 + 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MOD,
		S_OFS,
		S_PHASE,
		S_CAR,
		S_AMP,
		S_SUM,
		S_OUT
	} state_t;

	state_t state_q;

	fmv_pkg::cfg_t cfg;

	logic            in_acc;
	logic            voice_ok;
	logic [AW-1:0]   vaddr;
	logic            is_start;
	logic            is_render;

	logic [PH_W-1:0]   ph_rd;
	logic [NOTE_W-1:0] note_rd;
	logic              ph_we;
	logic [PH_W-1:0]   ph_wdata;
	logic              note_we;
	logic              mem_re;

	logic [PHASE_BITS-1:0] rom_phase;
	logic signed [15:0]    sine;

	logic [AW-1:0]         addr_q;
	logic [15:0]           env_q;
	logic signed [15:0]    mix_q;
	logic [PHASE_BITS-1:0] car_q;
	logic [PHASE_BITS-1:0] mph_q;
	logic [15:0]           amp_q;
	logic [42:0]           p_q;
	logic [58:0]           pr_q;
	logic signed [32:0]    smi_q;
	logic signed [63:0]    prod_q;
	logic [30:0]           am_q;
	logic                  sneg_q;
	logic [46:0]           mag_q;
	logic signed [15:0]    res_q;

	logic [PHASE_BITS-1:0] ph_sum;
	logic [PHASE_BITS-1:0] car_new;
	logic [PHASE_BITS-1:0] mod_new;
	logic [14:0]           sc_mag;
	logic [47:0]           rnd;
	logic signed [19:0]    sum;
	logic signed [15:0]    sat;
	logic                  out_free;
	logic                  out_load;

	fmv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign voice_ok  = (32'(voice) < VOICES);
	assign vaddr     = AW'(voice);
	assign is_start  = (fmv_pkg::action_t'(action) == fmv_pkg::ACT_START);
	assign is_render = (fmv_pkg::action_t'(action) == fmv_pkg::ACT_RENDER);

	assign note_we = in_acc && is_start && voice_ok;
	assign mem_re  = in_acc && is_render && voice_ok;
	assign ph_we   = (state_q == S_PHASE);

	fmv_voice_mem #(
		.DEPTH (VOICES),
		.AW    (AW),
		.WIDTH (NOTE_W)
	) u_note_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (note_we),
		.waddr  (vaddr),
		.wdata  ({frequency_hz, velocity}),
		.re     (mem_re),
		.raddr  (vaddr),
		.rdata  (note_rd)
	);

	fmv_voice_mem #(
		.DEPTH (VOICES),
		.AW    (AW),
		.WIDTH (PH_W)
	) u_phase_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ph_we),
		.waddr  (addr_q),
		.wdata  (ph_wdata),
		.re     (mem_re),
		.raddr  (vaddr),
		.rdata  (ph_rd)
	);

	// modulator phase first, then the offset carrier phase
	assign rom_phase = (state_q == S_LOAD) ? ph_rd[PHASE_BITS-1:0] : ph_sum;

	fmv_sine_rom #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine (
		.clk   (clk),
		.phase (rom_phase),
		.sine  (sine)
	);

	assign ph_sum   = car_q + prod_q[OFS_SH +: PHASE_BITS];
	assign car_new  = car_q + p_q[CAR_SH +: PHASE_BITS];
	assign mod_new  = mph_q + pr_q[MOD_SH +: PHASE_BITS];
	assign ph_wdata = {car_new, mod_new};

	assign sc_mag = sine[15] ? 15'(-sine) : sine[14:0];

	// round the Q45 product back to Q15 and saturate the mix
	assign rnd = {1'b0, mag_q} + 48'd536870912;
	always_comb begin
		if (sneg_q) begin
			sum = 20'(mix_q) - $signed({2'b00, rnd[47:30]});
		end else begin
			sum = 20'(mix_q) + $signed({2'b00, rnd[47:30]});
		end
		if (sum > 20'sd32767) begin
			sat = 16'sh7fff;
		end else if (sum < -20'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = sum[15:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= vaddr;
			env_q  <= envelope_level;
			mix_q  <= mix_in;
			res_q  <= mix_in;
		end
		unique case (state_q)
			S_LOAD: begin
				car_q <= ph_rd[PH_W-1:PHASE_BITS];
				mph_q <= ph_rd[PHASE_BITS-1:0];
				amp_q <= note_rd[15:0];
				p_q   <= note_rd[NOTE_W-1:16] * cfg.phase_scale;
			end
			S_MOD: begin
				smi_q <= sine * $signed({1'b0, cfg.mod_index});
				pr_q  <= p_q * cfg.mod_ratio;
			end
			S_OFS: begin
				prod_q <= smi_q * $signed({1'b0, fmv_pkg::INV_TWO_PI_Q32});
			end
			S_CAR: begin
				am_q   <= sc_mag * amp_q;
				sneg_q <= sine[15];
			end
			S_AMP: begin
				mag_q <= am_q * env_q;
			end
			S_SUM: begin
				res_q <= sat;
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid || out_ready;
	assign out_load = (state_q == S_OUT) && out_free;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			mix_out   <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
				mix_out   <= res_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && is_render) begin
						state_q <= voice_ok ? S_LOAD : S_OUT;
					end
				end
				S_LOAD:  state_q <= S_MOD;
				S_MOD:   state_q <= S_OFS;
				S_OFS:   state_q <= S_PHASE;
				S_PHASE: state_q <= S_CAR;
				S_CAR:   state_q <= S_AMP;
				S_AMP:   state_q <= S_SUM;
				S_SUM:   state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FMV_ASSERT_NEXT(a_render_busy, in_acc && is_render, !in_ready, "render transaction did not block input")
	`FMV_ASSERT_NEXT(a_start_one_cycle, in_acc && is_start, in_ready && !$rose(out_valid), "start transaction produced a result or stalled")
	`FMV_ASSERT_NOW(a_out_from_seq, $rose(out_valid), $past(state_q == S_OUT), "result loaded outside the output state")
	`FMV_ASSERT_NOW(a_phase_wb_idle_in, ph_we, !in_ready, "phase write-back while input open")

endmodule

// ===== rtl/fmv_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_regs
// APB register file: modulation index, frequency ratio and phase scale.
// ----------------------------------------------------------------------------
module fmv_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fmv_pkg::ADDR_W-1:0]    paddr,
	input  logic [fmv_pkg::DATA_W-1:0]    pwdata,
	output logic [fmv_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output fmv_pkg::cfg_t                 cfg
);

	fmv_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = fmv_pkg::reg_idx_t'(paddr[fmv_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mod_index   <= fmv_pkg::MOD_INDEX_RST;
			cfg.mod_ratio   <= fmv_pkg::MOD_RATIO_RST;
			cfg.phase_scale <= fmv_pkg::PHASE_SCALE_RST;
		end else if (wr_en) begin
			unique case (idx)
				fmv_pkg::REG_MOD_INDEX:   cfg.mod_index   <= pwdata[15:0];
				fmv_pkg::REG_MOD_RATIO:   cfg.mod_ratio   <= pwdata[15:0];
				fmv_pkg::REG_PHASE_SCALE: cfg.phase_scale <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fmv_pkg::REG_MOD_INDEX:   prdata = fmv_pkg::DATA_W'(cfg.mod_index);
			fmv_pkg::REG_MOD_RATIO:   prdata = fmv_pkg::DATA_W'(cfg.mod_ratio);
			fmv_pkg::REG_PHASE_SCALE: prdata = fmv_pkg::DATA_W'(cfg.phase_scale);
			default:                  prdata = '0;
		endcase
	end

endmodule

// ===== rtl/fmv_voice_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_voice_mem
// Per-voice state memory, one write and one registered read port.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module fmv_voice_mem #(
	parameter int unsigned DEPTH = fmv_pkg::VOICES_DEF,
	parameter int unsigned AW    = 3,
	parameter int unsigned WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/fmv_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_sine_rom
// Quarter-wave sine ROM with quadrant mirroring, registered read.
// Output range is +-32767, valid in the cycle after the phase is applied.
// ----------------------------------------------------------------------------
module fmv_sine_rom #(
	parameter int unsigned PHASE_BITS      = fmv_pkg::PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = fmv_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic [PHASE_BITS-1:0] phase,
	output logic signed [15:0]    sine
);

	localparam int unsigned QSIZE = 1 << SINE_TABLE_BITS;

	typedef logic [14:0] entry_t;
	typedef entry_t tab_t [QSIZE+1];

	// Q30 odd polynomial for sin(pi/2 x), Horner form
	function automatic logic [63:0] poly_sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] r;
		x2 = (x * x) >> 30;
		r  = 64'd172272;
		r  = 64'd5026995    - ((x2 * r) >> 30);
		r  = 64'd85569306   - ((x2 * r) >> 30);
		r  = 64'd693598668  - ((x2 * r) >> 30);
		r  = 64'd1686629713 - ((x2 * r) >> 30);
		return (x * r) >> 30;
	endfunction

	function automatic tab_t build_tab();
		tab_t        t;
		logic [63:0] x;
		logic [63:0] v;
		for (int i = 0; i <= int'(QSIZE); i++) begin
			x = 64'(i) << (30 - SINE_TABLE_BITS);
			v = (poly_sin_q30(x) * 64'd32767 + 64'd536870912) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			t[i] = v[14:0];
		end
		return t;
	endfunction

	localparam tab_t SINE_TAB = build_tab();

	logic [SINE_TABLE_BITS+1:0] idx;
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] k;
	logic [SINE_TABLE_BITS:0]   addr;
	entry_t                     mag_q;
	logic                       neg_q;

	assign idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
	assign quad = idx[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
	assign k    = idx[SINE_TABLE_BITS-1:0];
	// mirror the second and fourth quadrants
	assign addr = quad[0] ? ((SINE_TABLE_BITS+1)'(QSIZE) - {1'b0, k}) : {1'b0, k};

	always_ff @(posedge clk) begin
		mag_q <= SINE_TAB[addr];
		neg_q <= quad[1];
	end

	assign sine = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule
